>>> rtl/krsu_pkg.sv
// Shared types and constants for the keyboard report slot update block.
package krsu_pkg;

  localparam int unsigned NKEYS = 6;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned NOUT  = 6;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] count_t;

endpackage

>>> rtl/krsu_slot_lane.sv
// One slot lane: decides whether a stored slot survives the new key list.
module krsu_slot_lane #(
  parameter int unsigned SLOTS = 6,
  parameter int unsigned LANE  = 0
) (
  input  krsu_pkg::key_t slots_i [SLOTS],
  input  krsu_pkg::key_t want_i  [krsu_pkg::NKEYS],
  output logic           keep_o
);

  logic hit;
  logic dup;

  always_comb begin
    hit = 1'b0;
    dup = 1'b0;
    for (int k = 0; k < krsu_pkg::NKEYS; k++) begin
      if (want_i[k] == slots_i[LANE]) begin
        hit = 1'b1;
      end
    end
    // An equal code in a lower slot has already consumed every matching entry.
    for (int j = 0; j < SLOTS; j++) begin
      if ((j < LANE) && (slots_i[j] == slots_i[LANE])) begin
        dup = 1'b1;
      end
    end
    keep_o = (slots_i[LANE] != '0) && hit && !dup;
  end

endmodule

>>> rtl/krsu_key_lane.sv
// One key lane: flags a wanted key that matches no stored slot.
module krsu_key_lane #(
  parameter int unsigned SLOTS = 6
) (
  input  krsu_pkg::key_t want_i,
  input  krsu_pkg::key_t slots_i [SLOTS],
  output logic           left_o
);

  logic seen;

  always_comb begin
    seen = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slots_i[s] == want_i) begin
        seen = 1'b1;
      end
    end
    left_o = (want_i != '0) && !seen;
  end

endmodule

>>> rtl/keyboard_report_slot_update.sv
// Top level of the keyboard report slot update block.
// An accepted request first compares slots and keys in parallel lanes in the match state,
// then places new keys in the place state, one key per cycle; a new request is taken
// only once the block is back in idle.
// The strobe cycle already shows busy low, and no strobe appears if nothing changed.
// Reset clears all slots and returns the block to idle; the receiver cannot stall.
module keyboard_report_slot_update #(
  parameter int unsigned SLOTS = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [7:0]               key_0_i,
  input  logic [7:0]               key_1_i,
  input  logic [7:0]               key_2_i,
  input  logic [7:0]               key_3_i,
  input  logic [7:0]               key_4_i,
  input  logic [7:0]               key_5_i,
  input  logic [2:0]               key_count_i,
  output logic                     valid_o,
  output logic [7:0]               slot_0_o,
  output logic [7:0]               slot_1_o,
  output logic [7:0]               slot_2_o,
  output logic [7:0]               slot_3_o,
  output logic [7:0]               slot_4_o,
  output logic [7:0]               slot_5_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_PLACE = 2'd2;

  localparam int unsigned KI_W = $clog2(krsu_pkg::NKEYS);
  localparam logic [KI_W-1:0] KI_LAST = KI_W'(krsu_pkg::NKEYS - 1);

  logic [1:0]      state_q, state_d;
  logic [KI_W-1:0] kidx_q, kidx_d;
  logic            changed_q, changed_d;
  logic            valid_q, valid_d;
  logic [krsu_pkg::NKEYS-1:0] rem_q, rem_d;

  krsu_pkg::key_t slots_q [SLOTS];
  krsu_pkg::key_t slots_d [SLOTS];
  krsu_pkg::key_t want_q  [krsu_pkg::NKEYS];
  krsu_pkg::key_t want_d  [krsu_pkg::NKEYS];
  krsu_pkg::key_t key_in  [krsu_pkg::NKEYS];
  krsu_pkg::key_t out_w   [krsu_pkg::NOUT];

  logic [SLOTS-1:0]           keep;
  logic [krsu_pkg::NKEYS-1:0] left;
  logic                       accept;
  logic                       free_found;

  assign accept = start_i && (state_q == ST_IDLE);

  assign key_in[0] = key_0_i;
  assign key_in[1] = key_1_i;
  assign key_in[2] = key_2_i;
  assign key_in[3] = key_3_i;
  assign key_in[4] = key_4_i;
  assign key_in[5] = key_5_i;

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    krsu_slot_lane #(
      .SLOTS(SLOTS),
      .LANE (s)
    ) u_slot_lane (
      .slots_i(slots_q),
      .want_i (want_q),
      .keep_o (keep[s])
    );
  end

  for (genvar k = 0; k < krsu_pkg::NKEYS; k++) begin : g_key
    krsu_key_lane #(
      .SLOTS(SLOTS)
    ) u_key_lane (
      .want_i (want_q[k]),
      .slots_i(slots_q),
      .left_o (left[k])
    );
  end

  always_comb begin
    state_d    = state_q;
    kidx_d     = kidx_q;
    changed_d  = changed_q;
    valid_d    = 1'b0;
    rem_d      = rem_q;
    slots_d    = slots_q;
    want_d     = want_q;
    free_found = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // A count of seven exceeds every key index, so it acts as six.
          for (int k = 0; k < krsu_pkg::NKEYS; k++) begin
            want_d[k] = (krsu_pkg::count_t'(k) < key_count_i) ? key_in[k] : '0;
          end
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        changed_d = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
          if (!keep[s]) begin
            slots_d[s] = '0;
            if (slots_q[s] != '0) begin
              changed_d = 1'b1;
            end
          end
        end
        rem_d   = left;
        kidx_d  = '0;
        state_d = ST_PLACE;
      end
      ST_PLACE: begin
        if (rem_q[kidx_q]) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (!free_found && (slots_q[s] == '0)) begin
              free_found = 1'b1;
              slots_d[s] = want_q[kidx_q];
              changed_d  = 1'b1;
            end
          end
        end
        if (kidx_q == KI_LAST) begin
          valid_d = changed_d;
          state_d = ST_IDLE;
        end else begin
          kidx_d = kidx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kidx_q    <= '0;
      changed_q <= 1'b0;
      valid_q   <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slots_q[s] <= '0;
      end
    end else begin
      state_q   <= state_d;
      kidx_q    <= kidx_d;
      changed_q <= changed_d;
      valid_q   <= valid_d;
      slots_q   <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q <= want_d;
    rem_q  <= rem_d;
  end

  for (genvar j = 0; j < krsu_pkg::NOUT; j++) begin : g_out
    if (j < SLOTS) begin : g_live
      assign out_w[j] = slots_q[j];
    end else begin : g_zero
      assign out_w[j] = '0;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign slot_0_o = out_w[0];
  assign slot_1_o = out_w[1];
  assign slot_2_o = out_w[2];
  assign slot_3_o = out_w[3];
  assign slot_4_o = out_w[4];
  assign slot_5_o = out_w[5];

endmodule

>>> rtl/krsu_checker.sv
// Port-level checker for the keyboard report slot update block and its binding.
module krsu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Block did not turn busy after an accepted request.");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("Result strobe appeared while the block was busy.");

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("Result strobe lasted more than one cycle.");

  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !valid_o)
    else $error("Result strobe appeared right after a request was accepted.");

endmodule

bind keyboard_report_slot_update krsu_checker u_krsu_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .valid_o(valid_o)
);
